@@ src/lge_pkg.sv @@
// Shared types and constants for the life grid engine.
// Command codes, controller states, control and status bundles.
// No dependencies.
package lge_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_FETCH,
    ST_WR_APPLY,
    ST_RD_FETCH,
    ST_RD_APPLY,
    ST_STEP_FETCH,
    ST_STEP_LOAD,
    ST_STEP_RUN
  } state_t;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COORD_W = 5;
  localparam int unsigned COUNT_W = 4;

  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;
  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;

  typedef struct packed {
    logic capture;
    logic rd_cell;
    logic wr_cell;
    logic out_load;
    logic step_start;
    logic step_load;
    logic step_row;
  } ctrl_t;

  typedef struct packed {
    logic last_row;
    logic out_full;
  } stat_t;

endpackage

@@ src/lge_ctrl.sv @@
// Controller state machine for the life grid engine.
// Sequences cell reads, cell writes and generation steps; depends on lge_pkg.
module lge_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [lge_pkg::CMD_W-1:0]  command,
  output logic                       in_stall,
  input  lge_pkg::stat_t             stat,
  output lge_pkg::ctrl_t             ctrl
);
  import lge_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  cmd_t   cmd;

  assign cmd      = cmd_t'(command);
  assign in_stall = (state != ST_IDLE) || ((cmd == CMD_READ) && stat.out_full);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_WRITE: state_next = ST_WR_FETCH;
            CMD_READ:  state_next = ST_RD_FETCH;
            CMD_STEP:  state_next = ST_STEP_FETCH;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_WR_FETCH:   state_next = ST_WR_APPLY;
      ST_WR_APPLY:   state_next = ST_IDLE;
      ST_RD_FETCH:   state_next = ST_RD_APPLY;
      ST_RD_APPLY:   state_next = ST_IDLE;
      ST_STEP_FETCH: state_next = ST_STEP_LOAD;
      ST_STEP_LOAD:  state_next = ST_STEP_RUN;
      ST_STEP_RUN: begin
        if (stat.last_row) begin
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.capture = accept;
    case (state)
      ST_WR_FETCH:   ctrl.rd_cell    = 1'b1;
      ST_WR_APPLY:   ctrl.wr_cell    = 1'b1;
      ST_RD_FETCH:   ctrl.rd_cell    = 1'b1;
      ST_RD_APPLY:   ctrl.out_load   = 1'b1;
      ST_STEP_FETCH: ctrl.step_start = 1'b1;
      ST_STEP_LOAD:  ctrl.step_load  = 1'b1;
      ST_STEP_RUN:   ctrl.step_row   = 1'b1;
      default:       ctrl.capture    = accept;
    endcase
  end

endmodule

@@ src/lge_datapath.sv @@
// Datapath for the life grid engine: row memory, three-row window,
// neighbour count logic, row counter and result register; depends on lge_pkg.
module lge_datapath #(
  parameter int NUM_COLS = 32,
  parameter int NUM_ROWS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lge_pkg::COORD_W-1:0]  row,
  input  logic [lge_pkg::COORD_W-1:0]  col,
  input  logic                         value,
  input  lge_pkg::ctrl_t               ctrl,
  output lge_pkg::stat_t               stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         cell_value
);
  import lge_pkg::*;

  localparam int AW = $clog2(NUM_ROWS);
  localparam int CW = $clog2(NUM_COLS);
  localparam logic [AW:0] HEIGHT_W = (AW + 1)'(NUM_ROWS);

  logic [NUM_COLS-1:0]    mem [NUM_ROWS];
  logic [NUM_ROWS-1:0]    row_valid;
  logic [NUM_COLS-1:0]    rd_data;
  logic                   rd_vld;
  logic [NUM_COLS-1:0]    rd_eff;

  logic [COORD_W-1:0]     row_q;
  logic [COORD_W-1:0]     col_q;
  logic                   value_q;
  logic                   row_ok;
  logic                   col_ok;
  logic [AW+COORD_W-1:0]  row_ext;
  logic [CW+COORD_W-1:0]  col_ext;
  logic [AW-1:0]          row_addr;
  logic [CW-1:0]          col_idx;

  logic [AW-1:0]          idx;
  logic [AW:0]            idx_p1;
  logic [AW:0]            idx_p2;
  logic [NUM_COLS-1:0]    prev;
  logic [NUM_COLS-1:0]    cur;
  logic [NUM_COLS-1:0]    nxt_eff;
  logic [NUM_COLS-1:0]    new_row;
  logic [NUM_COLS-1:0]    cell_row;

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [NUM_COLS-1:0]    wr_data;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      row_q   <= row;
      col_q   <= col;
      value_q <= value;
    end
  end

  assign row_ok   = 32'(row_q) < 32'(NUM_ROWS);
  assign col_ok   = 32'(col_q) < 32'(NUM_COLS);
  assign row_ext  = {{AW{1'b0}}, row_q};
  assign col_ext  = {{CW{1'b0}}, col_q};
  assign row_addr = row_ext[AW-1:0];
  assign col_idx  = col_ext[CW-1:0];

  assign idx_p1 = {1'b0, idx} + (AW + 1)'(1);
  assign idx_p2 = {1'b0, idx} + (AW + 1)'(2);

  assign rd_eff  = rd_vld ? rd_data : '0;
  assign nxt_eff = (idx_p1 < HEIGHT_W) ? rd_eff : '0;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (ctrl.rd_cell) begin
      rd_en   = row_ok;
      rd_addr = row_addr;
    end else if (ctrl.step_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (ctrl.step_load) begin
      rd_en   = 1'b1;
      rd_addr = AW'(1);
    end else if (ctrl.step_row) begin
      rd_en   = idx_p2 < HEIGHT_W;
      rd_addr = idx_p2[AW-1:0];
    end
  end

  always_comb begin
    cell_row          = rd_eff;
    cell_row[col_idx] = value_q;
  end

  always_comb begin
    logic [NUM_COLS+1:0] p;
    logic [NUM_COLS+1:0] m;
    logic [NUM_COLS+1:0] n;
    logic [COUNT_W-1:0]  cnt;
    p = {1'b0, prev, 1'b0};
    m = {1'b0, cur, 1'b0};
    n = {1'b0, nxt_eff, 1'b0};
    for (int c = 0; c < NUM_COLS; c++) begin
      cnt = COUNT_W'(p[c]) + COUNT_W'(p[c+1]) + COUNT_W'(p[c+2])
          + COUNT_W'(m[c]) + COUNT_W'(m[c+2])
          + COUNT_W'(n[c]) + COUNT_W'(n[c+1]) + COUNT_W'(n[c+2]);
      new_row[c] = (cnt == BIRTH_COUNT) || (cur[c] && (cnt == SURVIVE_COUNT));
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = new_row;
    if (ctrl.wr_cell) begin
      wr_en   = row_ok && col_ok;
      wr_addr = row_addr;
      wr_data = cell_row;
    end else if (ctrl.step_row) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_start) begin
      idx  <= '0;
      prev <= '0;
    end else if (ctrl.step_row) begin
      idx  <= idx_p1[AW-1:0];
      prev <= cur;
    end
    if (ctrl.step_load) begin
      cur <= rd_eff;
    end else if (ctrl.step_row) begin
      cur <= nxt_eff;
    end
  end

  assign stat = '{last_row: (idx == AW'(NUM_ROWS - 1)),
                  out_full: (out_valid && out_stall)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      cell_value <= row_ok && col_ok && rd_eff[col_idx];
    end
  end

endmodule

@@ src/life_grid_engine_core.sv @@
// Life grid engine top level: bounded B3/S23 grid with cell read/write and step.
// Read and write words pass through a fetch state and an apply state; the read apply state loads the result register.
// A step word passes through fetch and load states, then runs one row per cycle through the row memory port.
// Inputs are taken only while idle; one word is worked on at a time.
// Synchronous reset clears the row valid bits, so the grid reads as all dead at once.
// Depends on lge_pkg, lge_ctrl and lge_datapath.
module life_grid_engine_core #(
  parameter int NUM_COLS = 32,
  parameter int NUM_ROWS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lge_pkg::CMD_W-1:0]    command,
  input  logic [lge_pkg::COORD_W-1:0]  row,
  input  logic [lge_pkg::COORD_W-1:0]  col,
  input  logic                         value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         cell_value
);
  import lge_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  lge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  lge_datapath #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .row        (row),
    .col        (col),
    .value      (value),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_value (cell_value)
  );

endmodule

@@ tb/tb_life_grid_engine_core.sv @@
// Self-checking bench for life_grid_engine_core: cell writes, reads and generation steps
// checked against a shadow grid that applies the B3/S23 rule with dead cells past the edge.
// Depends on lge_pkg and the life_grid_engine_core RTL.
module tb_life_grid_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lge_pkg::*;

  localparam int GRID_W = 32;
  localparam int GRID_H = 32;
  localparam int RANDOM_WORDS = 1850;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               value;
  } grid_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = '0;
  logic [COORD_W-1:0] row = '0;
  logic [COORD_W-1:0] col = '0;
  logic value = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cell_value;

  grid_word_t pending_words[$];
  logic expected_cells[$];
  logic [GRID_W-1:0] shadow_grid [GRID_H] = '{default: '0};
  int total_words = 0;
  int counted_words = 0;
  int words_taken = 0;
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  life_grid_engine_core #(
    .NUM_COLS(GRID_W),
    .NUM_ROWS(GRID_H)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_value(cell_value)
  );

  always #4 clk = ~clk;

  function automatic void advance_generation();
    logic [GRID_W-1:0] prev [GRID_H];
    int n;
    prev = shadow_grid;
    for (int r = 0; r < GRID_H; r++) begin
      for (int c = 0; c < GRID_W; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_H &&
                c + dc >= 0 && c + dc < GRID_W)
              n += prev[r+dr][c+dc];
          end
        end
        shadow_grid[r][c] = (n == BIRTH_COUNT) || (prev[r][c] && n == SURVIVE_COUNT);
      end
    end
  endfunction

  function automatic void apply_grid_word(grid_word_t w);
    bit on_grid;
    on_grid = (w.row < GRID_H) && (w.col < GRID_W);
    case (w.cmd)
      CMD_WRITE: begin
        if (on_grid)
          shadow_grid[w.row][w.col] = w.value;
      end
      CMD_READ: expected_cells.push_back(on_grid ? shadow_grid[w.row][w.col] : 1'b0);
      CMD_STEP: advance_generation();
      default: ;
    endcase
  endfunction

  function automatic int idle_pct(bit for_sender);
    if (words_taken < total_words / 3)
      return for_sender ? 10 : 53;
    if (words_taken < 2 * total_words / 3)
      return for_sender ? 53 : 10;
    return 0;
  endfunction

  task automatic push_word(logic [CMD_W-1:0] cmd, int r, int c, logic v);
    grid_word_t w;
    w.cmd = cmd;
    w.row = r[COORD_W-1:0];
    w.col = c[COORD_W-1:0];
    w.value = v;
    pending_words.push_back(w);
    if (cmd != CMD_UNUSED)
      counted_words++;
  endtask

  function automatic int pick_coord();
    int edges [4] = '{0, 1, 30, 31};
    if ($urandom_range(3) == 0)
      return edges[$urandom_range(3)];
    return $urandom_range(31);
  endfunction

  // driver
  always @(posedge clk) begin : drive_words
    grid_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        w.cmd = command;
        w.row = row;
        w.col = col;
        w.value = value;
        apply_grid_word(w);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          command <= w.cmd;
          row <= w.row;
          col <= w.col;
          value <= w.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off early in the last phase
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && total_words > 0 && words_taken >= 2 * total_words / 3 + 30) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  // monitor
  always @(posedge clk) begin : check_cells
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $error("cell_value: no word expected, actual %0b", cell_value);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (cell_value !== want) begin
          $error("cell_value: expected %0b, actual %0b", want, cell_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run_control
    int r0;
    int c0;
    int n;
    int kind;
    // corners, unused command, and a blinker against the top edge
    push_word(CMD_READ, 0, 0, 1'b0);
    push_word(CMD_WRITE, 0, 0, 1'b1);
    push_word(CMD_WRITE, 31, 31, 1'b1);
    push_word(CMD_WRITE, 0, 31, 1'b1);
    push_word(CMD_WRITE, 31, 0, 1'b1);
    push_word(CMD_READ, 0, 0, 1'b0);
    push_word(CMD_READ, 31, 31, 1'b1);
    push_word(CMD_READ, 0, 31, 1'b0);
    push_word(CMD_READ, 31, 0, 1'b1);
    push_word(CMD_WRITE, 31, 31, 1'b0);
    push_word(CMD_READ, 31, 31, 1'b1);
    push_word(CMD_UNUSED, 5, 5, 1'b1);
    push_word(CMD_READ, 5, 5, 1'b0);
    push_word(CMD_WRITE, 0, 14, 1'b1);
    push_word(CMD_WRITE, 0, 15, 1'b1);
    push_word(CMD_WRITE, 0, 16, 1'b1);
    push_word(CMD_STEP, 0, 0, 1'b0);
    push_word(CMD_READ, 0, 15, 1'b0);
    push_word(CMD_READ, 1, 15, 1'b0);
    push_word(CMD_READ, 31, 15, 1'b0);
    push_word(CMD_READ, 0, 14, 1'b0);
    push_word(CMD_READ, 0, 0, 1'b0);
    push_word(CMD_STEP, 31, 31, 1'b1);
    push_word(CMD_READ, 0, 15, 1'b0);

    while (counted_words < RANDOM_WORDS + 24) begin
      kind = $urandom_range(9);
      r0 = pick_coord();
      c0 = pick_coord();
      if (kind <= 6) begin
        n = $urandom_range(8, 24);
        repeat (n) push_word(CMD_WRITE, r0 + $urandom_range(5), c0 + $urandom_range(5),
                             $urandom_range(3) != 0);
        repeat ($urandom_range(1, 3)) push_word(CMD_STEP, $urandom, $urandom, 1'($urandom));
        repeat ($urandom_range(6, 16))
          push_word(CMD_READ, r0 - 1 + $urandom_range(7), c0 - 1 + $urandom_range(7),
                    1'($urandom));
      end else if (kind == 7) begin
        repeat (10) push_word(CMD_W'($urandom_range(3)), $urandom, $urandom, 1'($urandom));
      end else if (kind == 8) begin
        repeat ($urandom_range(2, 4)) push_word(CMD_STEP, $urandom, $urandom, 1'($urandom));
        repeat (4) push_word(CMD_READ, pick_coord(), pick_coord(), 1'($urandom));
      end else begin
        repeat ($urandom_range(6, 14))
          push_word(CMD_W'($urandom_range(2)), r0 + $urandom_range(4), c0 + $urandom_range(4),
                    1'($urandom));
      end
    end
    total_words = pending_words.size();

    @(posedge clk);
    while (rst || pending_words.size() > 0 || in_valid || expected_cells.size() > 0)
      @(posedge clk);
    repeat (GRID_H + 10) @(posedge clk);
    if (errors == 0 && expected_cells.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

endmodule

@@ life_grid_engine_core.f @@
src/lge_pkg.sv
src/lge_ctrl.sv
src/lge_datapath.sv
src/life_grid_engine_core.sv
tb/tb_life_grid_engine_core.sv
